// ===== hdl/bchd_pkg.sv =====
// Shared types and constants for the button click/hold detector.
// No dependencies; imported by every other file in hdl/.
`default_nettype none

package bchd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRelWindow = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHold      = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDblWindow = 2'd3;

  // Reset values of the configuration registers (ms)
  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] RelWindowRst = 16'd500;
  localparam logic [CfgW-1:0] HoldRst      = 16'd1000;
  localparam logic [CfgW-1:0] DblWindowRst = 16'd300;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_HOLD   = 3'd3,
    EV_REL    = 3'd4
  } event_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_PRESSED  = 5'b00100,
    PH_WAIT2    = 5'b01000,
    PH_HOLD     = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] release_window_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] double_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             pressed;
    logic             edge_seen;
  } poll_t;

endpackage

`default_nettype wire

// ===== hdl/bchd_cfg.sv =====
// Configuration register bank of the button detector.
// Depends on bchd_pkg.
`default_nettype none

module bchd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bchd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bchd_pkg::CfgW-1:0]     cfg_data_i,
  output bchd_pkg::cfg_t                cfg_o
);
  import bchd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= DebounceRst;
      cfg_q.release_window_ms <= RelWindowRst;
      cfg_q.hold_ms           <= HoldRst;
      cfg_q.double_window_ms  <= DblWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce:  cfg_q.debounce_ms       <= cfg_data_i;
        RegRelWindow: cfg_q.release_window_ms <= cfg_data_i;
        RegHold:      cfg_q.hold_ms           <= cfg_data_i;
        RegDblWindow: cfg_q.double_window_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/bchd_fsm.sv =====
// Five-phase press tracker: phase, timestamp marks and next-state logic.
// Depends on bchd_pkg.
`default_nettype none

module bchd_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bchd_pkg::poll_t   poll_i,
  input  bchd_pkg::cfg_t    cfg_i,
  output bchd_pkg::event_e  event_o,
  output logic              busy_o
);
  import bchd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] mark_q, mark_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             pend_q, pend_d;
  logic             active_q, active_d;
  logic [TimeW-1:0] since_mark, held;
  event_e           ev;

  assign since_mark = poll_i.now_ms - mark_q;
  assign held       = poll_i.now_ms - start_q;

  always_comb begin
    phase_d  = phase_q;
    mark_d   = mark_q;
    start_d  = start_q;
    pend_d   = pend_q;
    active_d = active_q;
    ev       = EV_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (poll_i.edge_seen && poll_i.pressed) begin
          phase_d  = PH_DEBOUNCE;
          mark_d   = poll_i.now_ms;
          active_d = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        if (since_mark >= {16'd0, cfg_i.debounce_ms}) begin
          if (poll_i.pressed) begin
            phase_d = PH_PRESSED;
            start_d = poll_i.now_ms;
          end else begin
            phase_d  = PH_IDLE;
            active_d = 1'b0;
          end
        end
      end
      PH_PRESSED: begin
        if (held <= {16'd0, cfg_i.release_window_ms} && !poll_i.pressed) begin
          if (pend_q) begin
            pend_d   = 1'b0;
            phase_d  = PH_IDLE;
            active_d = 1'b0;
            ev       = EV_DOUBLE;
          end else begin
            pend_d  = 1'b1;
            mark_d  = poll_i.now_ms;
            phase_d = PH_WAIT2;
          end
        end else if (held >= {16'd0, cfg_i.hold_ms} && poll_i.pressed) begin
          phase_d = PH_HOLD;
          pend_d  = 1'b0;
          ev      = EV_HOLD;
        end else if (!poll_i.pressed) begin
          // long press released after the window: drop silently
          phase_d  = PH_IDLE;
          active_d = 1'b0;
        end
      end
      PH_WAIT2: begin
        if (poll_i.pressed) begin
          phase_d = PH_DEBOUNCE;
          mark_d  = poll_i.now_ms;
          start_d = poll_i.now_ms;
        end else if (since_mark >= {16'd0, cfg_i.double_window_ms}) begin
          pend_d   = 1'b0;
          phase_d  = PH_IDLE;
          active_d = 1'b0;
          ev       = EV_CLICK;
        end
      end
      PH_HOLD: begin
        if (!poll_i.pressed) begin
          phase_d  = PH_IDLE;
          active_d = 1'b0;
          ev       = EV_REL;
        end
      end
      default: begin
        phase_d  = PH_IDLE;
        active_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      mark_q   <= '0;
      start_q  <= '0;
      pend_q   <= 1'b0;
      active_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      mark_q   <= mark_d;
      start_q  <= start_d;
      pend_q   <= pend_d;
      active_q <= active_d;
    end
  end

  assign event_o = ev;
  assign busy_o  = active_d;

endmodule

`default_nettype wire

// ===== hdl/button_click_hold_detector_unit.sv =====
// Top level of the push-button click / double-click / hold detector.
// Depends on bchd_pkg, bchd_cfg and bchd_fsm.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  --------------------------------
// poll      in         in_valid_i / in_ready_o   now_ms_i, pin_level_i, edge_seen_i
// result    out        out_valid_o / out_ready_i event_code_o, busy_res_o
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One poll per clock sustained while result beats are taken; a poll passes
// through the input register, where the phase logic (a 32-bit subtract and
// compare) settles, and then into the result register, which presents its
// result beat.
// Reset puts the phase to idle, clears marks and loads register defaults.
// A stalled result holds the result register; the input register still takes
// a beat, and the poll channel stalls only when both registers are full.

module button_click_hold_detector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // poll channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bchd_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          pin_level_i,
  input  logic                          edge_seen_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_code_o,
  output logic                          busy_res_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [bchd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bchd_pkg::CfgW-1:0]     cfg_data_i
);
  import bchd_pkg::*;

  cfg_t   cfg;
  poll_t  poll_q;
  logic   in_vld_q;
  logic   out_vld_q;
  event_e ev;
  event_e ev_q;
  logic   busy;
  logic   busy_q;
  logic   step;

  bchd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held poll when the result register is free or being drained.
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  // Input register: hold the poll; the pin is active low, so store "pressed".
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      poll_q.now_ms    <= now_ms_i;
      poll_q.pressed   <= ~pin_level_i;
      poll_q.edge_seen <= edge_seen_i;
    end
  end

  bchd_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .poll_i  (poll_q),
    .cfg_i   (cfg),
    .event_o (ev),
    .busy_o  (busy)
  );

  // Result register: load on step, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ev_q   <= ev;
      busy_q <= busy;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_code_o = ev_q;
  assign busy_res_o   = busy_q;

  // Click, double click and release all end the press, so busy drops with them.
  a_end_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (ev_q == EV_CLICK || ev_q == EV_DOUBLE || ev_q == EV_REL))
      |-> !busy_q)
    else $error("terminal event reported while busy");

  a_hold_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ev_q == EV_HOLD) |-> busy_q)
    else $error("hold event reported while idle");

  a_step_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("advanced poll produced no result");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("poll channel stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== test/bchd_checker.sv =====
// Result checker for the button click/hold detector: watches the poll, result and
// configuration ports, tracks the button phase itself and compares every result beat.
// Depends on bchd_pkg for the register indexes, reset values and event codes.
module bchd_checker
  import bchd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               pin_level_i,
  input  logic               edge_seen_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         event_code_i,
  input  logic               busy_res_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o,
  output int unsigned        results_o,
  output int unsigned        events_o
);

  typedef struct packed {
    event_e code;
    logic   busy;
  } outcome_t;

  cfg_t             cfg_q;
  phase_e           phase_q;
  logic [TimeW-1:0] mark_q;
  logic [TimeW-1:0] press_q;
  logic             first_click_q;
  logic             active_q;

  outcome_t    expected_q[$];
  outcome_t    head;
  int unsigned mism_cnt;
  int unsigned result_cnt;
  int unsigned event_cnt;

  // Advance the button phase by one poll and queue the outcome it must produce.
  task automatic track_poll(input logic [TimeW-1:0] now, input logic pressed,
                            input logic edge_in);
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] held;
    event_e           code;
    code  = EV_NONE;
    since = now - mark_q;
    held  = now - press_q;
    if (phase_q != PH_IDLE || edge_in) begin
      case (phase_q)
        PH_IDLE: begin
          if (pressed) begin
            phase_q  = PH_DEBOUNCE;
            mark_q   = now;
            active_q = 1'b1;
          end
        end
        PH_DEBOUNCE: begin
          if (since >= TimeW'(cfg_q.debounce_ms)) begin
            if (pressed) begin
              phase_q = PH_PRESSED;
              press_q = now;
            end else begin
              phase_q  = PH_IDLE;
              active_q = 1'b0;
            end
          end
        end
        PH_PRESSED: begin
          if (held <= TimeW'(cfg_q.release_window_ms) && !pressed) begin
            if (first_click_q) begin
              first_click_q = 1'b0;
              phase_q       = PH_IDLE;
              active_q      = 1'b0;
              code          = EV_DOUBLE;
            end else begin
              first_click_q = 1'b1;
              mark_q        = now;
              phase_q       = PH_WAIT2;
            end
          end else if (held >= TimeW'(cfg_q.hold_ms) && pressed) begin
            phase_q       = PH_HOLD;
            first_click_q = 1'b0;
            code          = EV_HOLD;
          end else if (!pressed) begin
            // released after the click window: drop back silently
            phase_q  = PH_IDLE;
            active_q = 1'b0;
          end
        end
        PH_WAIT2: begin
          if (pressed) begin
            phase_q = PH_DEBOUNCE;
            mark_q  = now;
            press_q = now;
          end else if (since >= TimeW'(cfg_q.double_window_ms)) begin
            first_click_q = 1'b0;
            phase_q       = PH_IDLE;
            active_q      = 1'b0;
            code          = EV_CLICK;
          end
        end
        PH_HOLD: begin
          if (!pressed) begin
            phase_q  = PH_IDLE;
            active_q = 1'b0;
            code     = EV_REL;
          end
        end
        default: begin
          phase_q  = PH_IDLE;
          active_q = 1'b0;
        end
      endcase
    end
    expected_q.push_back('{code: code, busy: active_q});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         = '{debounce_ms: DebounceRst, release_window_ms: RelWindowRst,
                        hold_ms: HoldRst, double_window_ms: DblWindowRst};
      phase_q       = PH_IDLE;
      mark_q        = '0;
      press_q       = '0;
      first_click_q = 1'b0;
      active_q      = 1'b0;
      expected_q.delete();
      mism_cnt      = 0;
      result_cnt    = 0;
      event_cnt     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDebounce:  cfg_q.debounce_ms       = cfg_data_i;
          RegRelWindow: cfg_q.release_window_ms = cfg_data_i;
          RegHold:      cfg_q.hold_ms           = cfg_data_i;
          RegDblWindow: cfg_q.double_window_ms  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        track_poll(now_ms_i, !pin_level_i, edge_seen_i);
      end
      if (out_valid_i && out_ready_i) begin
        result_cnt++;
        if (event_code_i != EV_NONE) event_cnt++;
        if (expected_q.size() == 0) begin
          if (mism_cnt < 10) begin
            $display("%0t: result beat with nothing outstanding: event %0d busy %0b",
                     $time, event_code_i, busy_res_i);
          end
          mism_cnt++;
        end else begin
          head = expected_q.pop_front();
          if (event_code_i !== head.code || busy_res_i !== head.busy) begin
            if (mism_cnt < 10) begin
              $display("%0t: got event %0d busy %0b, expected event %0d busy %0b",
                       $time, event_code_i, busy_res_i, head.code, head.busy);
            end
            mism_cnt++;
          end
        end
      end
    end
    mismatches_o  <= mism_cnt;
    outstanding_o <= expected_q.size();
    results_o     <= result_cnt;
    events_o      <= event_cnt;
  end

endmodule

// ===== test/button_click_hold_detector_unit_tb.sv =====
// Testbench top for button_click_hold_detector_unit: clock, reset, poll and result
// traffic, register writes and the verdict. Depends on bchd_pkg and bchd_checker.
module button_click_hold_detector_unit_tb;
  import bchd_pkg::*;

  // Pin is active low
  localparam logic PinDown = 1'b0;
  localparam logic PinUp   = 1'b1;
  // Cycles without any beat or register write before the run is declared hung
  localparam int unsigned IdleLimit = 2000;
  // Polls per randomized register setting
  localparam int unsigned PhaseItems = 110;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [TimeW-1:0]   now_ms_i;
  logic               pin_level_i;
  logic               edge_seen_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         event_code_o;
  logic               busy_res_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned events_seen;

  // Stimulus state: thresholds currently loaded (used only to shape gestures),
  // the millisecond cursor and the last pin level offered.
  int unsigned      deb_ms;
  int unsigned      rel_ms;
  int unsigned      hold_ms;
  int unsigned      dbl_ms;
  logic [TimeW-1:0] cursor_ms;
  logic             last_level;
  logic             gapless;
  int unsigned      polls_sent;
  int unsigned      settings_run;

  button_click_hold_detector_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .now_ms_i     (now_ms_i),
    .pin_level_i  (pin_level_i),
    .edge_seen_i  (edge_seen_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .busy_res_o   (busy_res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  bchd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .now_ms_i      (now_ms_i),
    .pin_level_i   (pin_level_i),
    .edge_seen_i   (edge_seen_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_code_i  (event_code_o),
    .busy_res_i    (busy_res_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results_seen),
    .events_o      (events_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one poll beat: idle a random number of cycles unless the current
  // gesture runs back to back, then hold valid and payload until taken.
  task automatic send_poll(input logic [TimeW-1:0] t, input logic level,
                           input logic edge_in);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    now_ms_i    <= t;
    pin_level_i <= level;
    edge_seen_i <= edge_in;
    do @(posedge clk_i); while (!in_ready_o);
    polls_sent++;
  endtask

  // Drop valid and wait until every poll has its result, plus pipeline slack.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all four registers on consecutive cycles; only call while drained.
  task automatic load_config(input int unsigned deb, input int unsigned rel,
                             input int unsigned hold, input int unsigned dbl);
    logic [CfgW-1:0] vals [4];
    vals[RegDebounce]  = CfgW'(deb);
    vals[RegRelWindow] = CfgW'(rel);
    vals[RegHold]      = CfgW'(hold);
    vals[RegDblWindow] = CfgW'(dbl);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    deb_ms  = deb;
    rel_ms  = rel;
    hold_ms = hold;
    dbl_ms  = dbl;
  endtask

  // Random duration scattered on both sides of a threshold.
  function automatic int unsigned near_ms(input int unsigned thr);
    int unsigned j;
    int unsigned v;
    j = thr / 8 + 2;
    v = thr + $urandom_range(0, 2 * j);
    return (v > j) ? v - j : 0;
  endfunction

  // Keep the pin at one level for len ms. The first poll flags the edge (mostly),
  // later ones advance time in random steps that land exactly on the segment end.
  task automatic hold_level(input logic level, input int unsigned len);
    int unsigned done;
    int unsigned step;
    logic        edge_flag;
    if (level != last_level) edge_flag = ($urandom_range(0, 15) != 0);
    else                     edge_flag = ($urandom_range(0, 7) == 0);
    last_level = level;
    cursor_ms += $urandom_range(0, 1);
    send_poll(cursor_ms, level, edge_flag);
    done = 0;
    while (done < len) begin
      step = $urandom_range(1, len / 3 + 1);
      if (step > len - done) step = len - done;
      cursor_ms += step;
      done      += step;
      send_poll(cursor_ms, level, $urandom_range(0, 7) == 0);
    end
  endtask

  // One button gesture: mostly well-formed clicks, double clicks and holds with
  // durations around the loaded thresholds, the rest bounces, noise and idle stretches.
  task automatic play_gesture();
    int unsigned kind;
    int unsigned n;
    logic        level;
    gapless = ($urandom_range(0, 3) == 0);
    kind    = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        hold_level(PinDown, deb_ms + near_ms(rel_ms));
        hold_level(PinUp, near_ms(dbl_ms));
      end
      3, 4: begin
        hold_level(PinDown, deb_ms + near_ms(rel_ms));
        hold_level(PinUp, $urandom_range(0, dbl_ms));
        hold_level(PinDown, deb_ms + near_ms(rel_ms));
        hold_level(PinUp, near_ms(dbl_ms));
      end
      5, 6: begin
        hold_level(PinDown, deb_ms + near_ms(hold_ms));
        hold_level(PinUp, near_ms(dbl_ms));
      end
      7: begin
        // contact bounce around the debounce time
        n     = $urandom_range(2, 6);
        level = PinDown;
        repeat (n) begin
          hold_level(level, $urandom_range(0, deb_ms + 2));
          level = ~level;
        end
        hold_level(PinUp, near_ms(dbl_ms));
      end
      8: begin
        // noise: random level and edge flag, occasional huge time jumps
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) cursor_ms += $urandom;
          else                           cursor_ms += $urandom_range(0, hold_ms + rel_ms);
          last_level = $urandom_range(0, 1);
          send_poll(cursor_ms, last_level, $urandom_range(0, 1));
        end
      end
      default: begin
        hold_level(PinUp, near_ms(deb_ms + rel_ms + dbl_ms));
      end
    endcase
  endtask

  // Load a register setting, then play gestures from a fresh time origin.
  task automatic run_setting(input int unsigned deb, input int unsigned rel,
                             input int unsigned hold, input int unsigned dbl);
    int unsigned start;
    drain();
    load_config(deb, rel, hold, dbl);
    // Start near the 32-bit wrap now and then so differences cross zero
    if ($urandom_range(0, 3) == 0) cursor_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * (deb + hold));
    else                           cursor_ms = $urandom;
    start = polls_sent;
    while (polls_sent - start < PhaseItems) play_gesture();
    settings_run++;
  endtask

  // Result side: stall each beat at random, with runs of back-to-back beats and
  // a long hold-off every 300 beats so the block fills and stalls its input.
  initial begin
    int unsigned stall;
    int unsigned fast_left;
    int unsigned beats;
    out_ready_i = 1'b0;
    fast_left   = 0;
    beats       = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (beats % 300 == 150) begin
        stall = 48;
      end else if (fast_left > 0) begin
        stall = 0;
        fast_left--;
      end else begin
        stall = $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0) fast_left = 30;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats++;
    end
  end

  // Hang detection: count cycles with no beat on either channel and no write.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("no beat for %0d cycles, %0d results still outstanding", IdleLimit, outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [TimeW-1:0] base;
    in_valid_i   = 1'b0;
    now_ms_i     = '0;
    pin_level_i  = PinUp;
    edge_seen_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegDebounce;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    deb_ms       = DebounceRst;
    rel_ms       = RelWindowRst;
    hold_ms      = HoldRst;
    dbl_ms       = DblWindowRst;
    cursor_ms    = '0;
    last_level   = PinUp;
    gapless      = 1'b0;
    polls_sent   = 0;
    settings_run = 1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed polls under reset thresholds (debounce 50, click 500, hold 1000,
    // double 300), each threshold hit exactly.
    base = 32'd1000;
    send_poll(base,        PinDown, 1'b0);  // idle without edge: ignored
    send_poll(base + 1,    PinUp,   1'b1);  // idle edge, pin up: nothing
    send_poll(base + 2,    PinDown, 1'b1);  // start debounce
    send_poll(base + 51,   PinDown, 1'b0);  // one ms short of settled
    send_poll(base + 52,   PinDown, 1'b0);  // settled: pressed
    send_poll(base + 552,  PinUp,   1'b1);  // release at exactly the click window
    send_poll(base + 851,  PinUp,   1'b0);  // one ms short of the double window
    send_poll(base + 852,  PinUp,   1'b0);  // single click
    base = 32'd5000;
    send_poll(base,        PinDown, 1'b1);
    send_poll(base + 50,   PinDown, 1'b0);
    send_poll(base + 100,  PinUp,   1'b1);
    send_poll(base + 200,  PinDown, 1'b1);  // second press inside the window
    send_poll(base + 250,  PinDown, 1'b0);
    send_poll(base + 300,  PinUp,   1'b1);  // double click
    base = 32'hFFFF_FE00;                   // hold across the 32-bit wrap
    send_poll(base,        PinDown, 1'b1);
    send_poll(base + 50,   PinDown, 1'b0);
    send_poll(base + 1049, PinDown, 1'b0);
    send_poll(base + 1050, PinDown, 1'b0);  // hold
    send_poll(base + 1501, PinUp,   1'b1);  // release after hold
    base = 32'd20000;
    send_poll(base,        PinDown, 1'b1);
    send_poll(base + 50,   PinDown, 1'b0);
    send_poll(base + 100,  PinUp,   1'b1);  // first click pending
    send_poll(base + 150,  PinDown, 1'b1);
    send_poll(base + 200,  PinUp,   1'b0);  // released after settling: idle, click kept
    send_poll(base + 9000, PinDown, 1'b1);
    send_poll(base + 9050, PinDown, 1'b0);
    send_poll(base + 9551, PinUp,   1'b1);  // released past the window: silent

    // Randomized gestures across settings, extremes and inverted orderings included
    last_level = PinUp;
    run_setting(3, 10, 16, 7);
    run_setting(0, 0, 0, 0);
    run_setting(65535, 65535, 65535, 65535);
    run_setting(0, 65535, 0, 65535);
    run_setting(65535, 0, 65535, 0);
    run_setting(2, 20, 8, 5);
    run_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_setting($urandom_range(0, 40), $urandom_range(0, 40),
                $urandom_range(0, 40), $urandom_range(0, 40));

    drain();
    repeat (8) @(negedge clk_i);

    $display("%0d polls under %0d register settings: directed edges, wrap, then gestures",
             polls_sent, settings_run);
    $display("%0d result beats checked, %0d carried a click, double, hold or release",
             results_seen, events_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
